>>> rtl/core/sstf_pkg.sv
`default_nettype none

package sstf_pkg;

    localparam int TRACK_BITS      = 16;
    localparam int REQ_BITS        = 4;
    localparam int CFG_BITS        = 5;
    localparam int CFG_IDX_BITS    = 1;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_REQ_DEF     = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REQUESTER_COUNT = 1'd1;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    localparam logic [CFG_BITS-1:0] CAPACITY_RESET  = 5'd16;
    localparam logic [CFG_BITS-1:0] REQ_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic                  action;
        logic [REQ_BITS-1:0]   requester_id;
        logic [TRACK_BITS-1:0] track;
    } req_item_t;

    typedef struct packed {
        logic [REQ_BITS-1:0]   served_requester;
        logic [TRACK_BITS-1:0] served_track;
    } svc_item_t;

    typedef struct packed {
        logic [REQ_BITS-1:0]   requester;
        logic [TRACK_BITS-1:0] track;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sstf_cell.sv
`default_nettype none

module sstf_cell #(
    parameter int DEPTH = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int INDEX = 0
) (
    input  wire                                clk,
    input  sstf_pkg::cell_ctrl_t               ctrl,
    input  sstf_pkg::entry_t                   load_entry,
    input  sstf_pkg::entry_t                   next_entry,
    input  wire  [sstf_pkg::TRACK_BITS-1:0]    head_track,
    input  wire                                head_known,
    input  wire  [sstf_pkg::TRACK_BITS-1:0]    prev_dist,
    input  wire  [$clog2(DEPTH)-1:0]           prev_idx,
    input  sstf_pkg::entry_t                   prev_entry,
    output sstf_pkg::entry_t                   entry,
    output logic [sstf_pkg::TRACK_BITS-1:0]    best_dist,
    output logic [$clog2(DEPTH)-1:0]           best_idx,
    output sstf_pkg::entry_t                   best_entry
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    sstf_pkg::entry_t                entry_reg;
    sstf_pkg::entry_t                entry_next;
    logic [sstf_pkg::TRACK_BITS-1:0] own_dist;
    logic                            take_own;
    logic [sstf_pkg::TRACK_BITS-1:0] best_dist_reg;
    logic [IW-1:0]                   best_idx_reg;
    sstf_pkg::entry_t                best_entry_reg;

    always_comb
    begin
        own_dist = (entry_reg.track >= head_track) ? entry_reg.track - head_track
                                                   : head_track - entry_reg.track;
        // strict compare keeps the oldest on a tie
        take_own = (INDEX == 0) || (ctrl.valid && head_known && (own_dist < prev_dist));
        priority if (ctrl.load)
            entry_next = load_entry;
        else if (ctrl.shift)
            entry_next = next_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (take_own)
        begin
            best_dist_reg  <= own_dist;
            best_idx_reg   <= MY_IDX;
            best_entry_reg <= entry_reg;
        end
        else
        begin
            best_dist_reg  <= prev_dist;
            best_idx_reg   <= prev_idx;
            best_entry_reg <= prev_entry;
        end
    end

    assign entry      = entry_reg;
    assign best_dist  = best_dist_reg;
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

`default_nettype wire

>>> rtl/core/sstf_disk_request_scheduler.sv
// A request that triggers a service yields its result after a check state (ST_CHECK), a sweep
// of the cell row (ST_SCAN) and an issue state (ST_EMIT) that waits while svc holds an unaccepted result.
// No new item is taken until the check, and any service it causes, is done; the
// nearest-track candidate moves one cell per cycle along the row.
// Reset: empty queue, head at track 0 and unknown, capacity 16, live requesters 16.
`default_nettype none

module sstf_disk_request_scheduler #(
    parameter int QUEUE_DEPTH    = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_REQUESTERS = sstf_pkg::MAX_REQ_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  req_valid,
    output logic                                 req_ready,
    input  sstf_pkg::req_item_t                  req,
    output logic                                 svc_valid,
    input  wire                                  svc_ready,
    output sstf_pkg::svc_item_t                  svc,
    input  wire                                  cfg_we,
    input  wire  [sstf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [sstf_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int IW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LW  = $clog2(MAX_REQUESTERS + 1);
    localparam int M1  = (CW > sstf_pkg::CFG_BITS) ? CW : sstf_pkg::CFG_BITS;
    localparam int CMP = (M1 > LW) ? M1 : LW;
    localparam int TB  = sstf_pkg::TRACK_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_EMIT} state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [LW-1:0]                live_reg, live_next;
    logic [sstf_pkg::CFG_BITS-1:0] cap_reg, cap_next;
    logic [TB-1:0]                head_reg, head_next;
    logic                         known_reg, known_next;
    logic [IW-1:0]                scan_reg, scan_next;
    logic                         svc_valid_reg, svc_valid_next;
    sstf_pkg::svc_item_t          svc_reg, svc_next;

    logic [CMP-1:0] cap_w, live_w, count_w, need_w, cfg_w;
    logic           accept, room, do_insert, emit_fire, serve;

    sstf_pkg::cell_ctrl_t ctrl       [QUEUE_DEPTH];
    sstf_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [TB-1:0]        best_dist  [QUEUE_DEPTH];
    logic [IW-1:0]        best_idx   [QUEUE_DEPTH];
    sstf_pkg::entry_t     best_entry [QUEUE_DEPTH];
    sstf_pkg::entry_t     new_entry;
    logic [IW-1:0]        pick;

    assign new_entry.requester = req.requester_id;
    assign new_entry.track     = req.track;
    assign pick                = best_idx[QUEUE_DEPTH-1];

    always_comb
    begin
        cap_w   = CMP'(cap_reg);
        if (cap_w == '0)
            cap_w = CMP'(1);
        else if (cap_w > CMP'(QUEUE_DEPTH))
            cap_w = CMP'(QUEUE_DEPTH);
        live_w  = CMP'(live_reg);
        count_w = CMP'(count_reg);
        need_w  = (live_w < cap_w) ? live_w : cap_w;
        serve   = (live_w != '0) && (count_w != '0) && (count_w >= need_w);
        cfg_w   = CMP'(cfg_data);
        if (cfg_w > CMP'(MAX_REQUESTERS))
            cfg_w = CMP'(MAX_REQUESTERS);

        accept    = req_valid && (state_reg == ST_IDLE);
        room      = count_w < cap_w;
        do_insert = accept && (req.action == sstf_pkg::ACT_REQUEST) && room;
        emit_fire = (state_reg == ST_EMIT) && (!svc_valid_reg || svc_ready);

        state_next     = state_reg;
        count_next     = count_reg;
        live_next      = live_reg;
        cap_next       = cap_reg;
        head_next      = head_reg;
        known_next     = known_reg;
        scan_next      = scan_reg;
        svc_valid_next = svc_valid_reg && !svc_ready;
        svc_next       = svc_reg;

        if (cfg_we)
        begin
            if (cfg_index == sstf_pkg::CFG_QUEUE_CAPACITY)
                cap_next = cfg_data;
            else if (cfg_index == sstf_pkg::CFG_REQUESTER_COUNT)
                live_next = LW'(cfg_w);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_insert)
                        count_next = count_reg + CW'(1);
                    else if (req.action == sstf_pkg::ACT_FINISH && live_reg != '0)
                        live_next = live_reg - LW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                scan_next  = '0;
                state_next = serve ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + IW'(1);
                if (scan_reg == IW'(QUEUE_DEPTH - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    svc_valid_next               = 1'b1;
                    svc_next.served_requester    = best_entry[QUEUE_DEPTH-1].requester;
                    svc_next.served_track        = best_entry[QUEUE_DEPTH-1].track;
                    head_next                    = best_entry[QUEUE_DEPTH-1].track;
                    known_next                   = 1'b1;
                    count_next                   = count_reg - CW'(1);
                    state_next                   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            live_reg      <= (MAX_REQUESTERS < int'(sstf_pkg::REQ_COUNT_RESET))
                             ? LW'(MAX_REQUESTERS) : LW'(sstf_pkg::REQ_COUNT_RESET);
            cap_reg       <= sstf_pkg::CAPACITY_RESET;
            head_reg      <= '0;
            known_reg     <= 1'b0;
            scan_reg      <= '0;
            svc_valid_reg <= 1'b0;
            svc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            live_reg      <= live_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            known_reg     <= known_next;
            scan_reg      <= scan_next;
            svc_valid_reg <= svc_valid_next;
            svc_reg       <= svc_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign svc_valid = svc_valid_reg;
    assign svc       = svc_reg;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            assign ctrl[i].valid = (CW'(i) < count_reg);
            assign ctrl[i].load  = do_insert && (count_reg == CW'(i));
            assign ctrl[i].shift = emit_fire && (IW'(i) >= pick);

            if (i == 0)
            begin : g_first
                sstf_cell #(.DEPTH(QUEUE_DEPTH), .INDEX(i)) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[i]),
                    .load_entry (new_entry),
                    .next_entry (cell_entry[i+1]),
                    .head_track (head_reg),
                    .head_known (known_reg),
                    .prev_dist  ('0),
                    .prev_idx   ('0),
                    .prev_entry ('0),
                    .entry      (cell_entry[i]),
                    .best_dist  (best_dist[i]),
                    .best_idx   (best_idx[i]),
                    .best_entry (best_entry[i])
                );
            end
            else if (i == QUEUE_DEPTH - 1)
            begin : g_last
                sstf_cell #(.DEPTH(QUEUE_DEPTH), .INDEX(i)) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[i]),
                    .load_entry (new_entry),
                    .next_entry (cell_entry[i]),
                    .head_track (head_reg),
                    .head_known (known_reg),
                    .prev_dist  (best_dist[i-1]),
                    .prev_idx   (best_idx[i-1]),
                    .prev_entry (best_entry[i-1]),
                    .entry      (cell_entry[i]),
                    .best_dist  (best_dist[i]),
                    .best_idx   (best_idx[i]),
                    .best_entry (best_entry[i])
                );
            end
            else
            begin : g_mid
                sstf_cell #(.DEPTH(QUEUE_DEPTH), .INDEX(i)) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[i]),
                    .load_entry (new_entry),
                    .next_entry (cell_entry[i+1]),
                    .head_track (head_reg),
                    .head_known (known_reg),
                    .prev_dist  (best_dist[i-1]),
                    .prev_idx   (best_idx[i-1]),
                    .prev_entry (best_entry[i-1]),
                    .entry      (cell_entry[i]),
                    .best_dist  (best_dist[i]),
                    .best_idx   (best_idx[i]),
                    .best_entry (best_entry[i])
                );
            end
        end
    endgenerate

endmodule

`default_nettype wire

>>> dv/sstf_service_checker.sv
`default_nettype none

module sstf_service_checker #(
    parameter int DEPTH    = sstf_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_LIVE = sstf_pkg::MAX_REQ_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  req_valid,
    input  wire                                  req_ready,
    input  sstf_pkg::req_item_t                  req,
    input  wire                                  svc_valid,
    input  wire                                  svc_ready,
    input  sstf_pkg::svc_item_t                  svc,
    input  wire                                  cfg_we,
    input  wire  [sstf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire  [sstf_pkg::CFG_BITS-1:0]        cfg_data,
    output int                                   errors,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [sstf_pkg::CFG_BITS-1:0]   capacity_reg;
    int                              live_cnt;
    int                              queued;
    bit                              head_set;
    logic [sstf_pkg::TRACK_BITS-1:0] head_trk;
    logic [sstf_pkg::TRACK_BITS-1:0] track_tab [DEPTH];
    logic [sstf_pkg::REQ_BITS-1:0]   owner_tab [DEPTH];
    sstf_pkg::svc_item_t             due_services [$];
    sstf_pkg::svc_item_t             want;
    sstf_pkg::svc_item_t             got;
    int                              fails;

    // Applies one accepted item; returns 1 with the service it causes, if any.
    function automatic bit next_service(input sstf_pkg::req_item_t item,
                                        output sstf_pkg::svc_item_t served);
        int cap;
        int need;
        int pick;
        int best;
        int span;
        int i;
        cap = (capacity_reg == '0) ? 1 :
              ((int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg));
        served = '0;
        if (item.action == sstf_pkg::ACT_REQUEST)
        begin
            if (queued < cap)
            begin
                owner_tab[queued] = item.requester_id;
                track_tab[queued] = item.track;
                queued++;
            end
        end
        else if (live_cnt > 0)
        begin
            live_cnt--;
        end
        need = (live_cnt < cap) ? live_cnt : cap;
        if (live_cnt == 0 || queued == 0 || queued < need)
        begin
            return 1'b0;
        end
        pick = 0;
        best = 0;
        if (head_set)
        begin
            for (i = 0; i < queued; i++)
            begin
                span = int'(track_tab[i]) - int'(head_trk);
                if (span < 0)
                begin
                    span = -span;
                end
                // strict compare keeps the oldest on a tie
                if (i == 0 || span < best)
                begin
                    best = span;
                    pick = i;
                end
            end
        end
        served.served_requester = owner_tab[pick];
        served.served_track     = track_tab[pick];
        head_trk = track_tab[pick];
        head_set = 1'b1;
        for (i = pick; i + 1 < queued; i++)
        begin
            owner_tab[i] = owner_tab[i + 1];
            track_tab[i] = track_tab[i + 1];
        end
        queued--;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg = sstf_pkg::CAPACITY_RESET;
            live_cnt     = (int'(sstf_pkg::REQ_COUNT_RESET) > MAX_LIVE)
                           ? MAX_LIVE : int'(sstf_pkg::REQ_COUNT_RESET);
            queued       = 0;
            head_set     = 1'b0;
            head_trk     = '0;
            fails        = 0;
            due_services.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (svc_valid && svc_ready)
            begin
                got = svc;
                if (due_services.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("%0t: unexpected service: requester %0d track %0d",
                                 $realtime, got.served_requester, got.served_track);
                    end
                end
                else
                begin
                    want = due_services.pop_front();
                    if (got.served_requester !== want.served_requester ||
                        got.served_track !== want.served_track)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display({"%0t: service mismatch: expected requester %0d ",
                                      "track %0d, got requester %0d track %0d"},
                                     $realtime, want.served_requester,
                                     want.served_track,
                                     got.served_requester, got.served_track);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == sstf_pkg::CFG_QUEUE_CAPACITY)
                begin
                    capacity_reg = cfg_data;
                end
                else if (cfg_index == sstf_pkg::CFG_REQUESTER_COUNT)
                begin
                    live_cnt = (int'(cfg_data) > MAX_LIVE) ? MAX_LIVE : int'(cfg_data);
                end
            end
            if (req_valid && req_ready)
            begin
                if (next_service(req, want))
                begin
                    due_services = {due_services, want};
                end
            end
            errors      <= fails;
            outstanding <= due_services.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              req_valid = 1'b0;
    logic                              req_ready;
    sstf_pkg::req_item_t               req = '0;
    logic                              svc_valid;
    logic                              svc_ready = 1'b0;
    sstf_pkg::svc_item_t               svc;
    logic                              cfg_we = 1'b0;
    logic [sstf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [sstf_pkg::CFG_BITS-1:0]     cfg_data = '0;
    int                                errors;
    int                                outstanding;
    int                                sent = 0;
    int                                quiet_cycles = 0;
    bit                                calm = 1'b0;
    bit                                hold_ask = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sstf_disk_request_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .svc_valid (svc_valid),
        .svc_ready (svc_ready),
        .svc       (svc),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sstf_service_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .svc_valid   (svc_valid),
        .svc_ready   (svc_ready),
        .svc         (svc),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    task automatic write_reg(input logic [sstf_pkg::CFG_IDX_BITS-1:0] idx,
                             input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= sstf_pkg::CFG_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_item(input logic act, input int rid, input int trk);
        sstf_pkg::req_item_t item;
        if (!calm && $urandom_range(4, 0) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        item.action       = act;
        item.requester_id = sstf_pkg::REQ_BITS'(rid);
        item.track        = sstf_pkg::TRACK_BITS'(trk);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent++;
    endtask

    // Block is idle once nothing is due and the last service scan has had time to end.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && !calm && $urandom_range(5, 0) == 0)
            begin
                stall = $urandom_range(5, 1);
            end
            svc_ready <= (stall == 0);
            if (stall > 0)
            begin
                stall--;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (svc_valid && svc_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int   phase;
        int   span;
        int   rid;
        int   trk;
        int   cap_pick;
        int   live_pick;
        logic act;
        phase = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // first service after reset takes the oldest, then nearest to head
        write_reg(sstf_pkg::CFG_QUEUE_CAPACITY, 3);
        write_reg(sstf_pkg::CFG_REQUESTER_COUNT, 31);
        send_item(sstf_pkg::ACT_REQUEST, 15, 'hFFFF);
        send_item(sstf_pkg::ACT_REQUEST, 0, 0);
        send_item(sstf_pkg::ACT_REQUEST, 3, 7);
        send_item(sstf_pkg::ACT_REQUEST, 9, 'h7FFF);
        send_item(sstf_pkg::ACT_FINISH, 0, 0);
        settle();
        // zero capacity acts as one: backlog drains one per item
        write_reg(sstf_pkg::CFG_QUEUE_CAPACITY, 0);
        send_item(sstf_pkg::ACT_FINISH, 15, 'hFFFF);
        send_item(sstf_pkg::ACT_FINISH, 1, 0);
        settle();
        // oversize capacity, ties, finishes down to none live
        write_reg(sstf_pkg::CFG_QUEUE_CAPACITY, 31);
        write_reg(sstf_pkg::CFG_REQUESTER_COUNT, 3);
        send_item(sstf_pkg::ACT_REQUEST, 5, 1000);
        send_item(sstf_pkg::ACT_REQUEST, 6, 3000);
        send_item(sstf_pkg::ACT_REQUEST, 7, 1000);
        send_item(sstf_pkg::ACT_REQUEST, 8, 500);
        send_item(sstf_pkg::ACT_REQUEST, 9, 1500);
        send_item(sstf_pkg::ACT_FINISH, 2, 0);
        send_item(sstf_pkg::ACT_FINISH, 4, 0);
        send_item(sstf_pkg::ACT_FINISH, 6, 0);
        send_item(sstf_pkg::ACT_FINISH, 8, 0);
        send_item(sstf_pkg::ACT_REQUEST, 2, 'h1234);
        settle();
        // full table drops the request; service resumes after a live count write
        write_reg(sstf_pkg::CFG_QUEUE_CAPACITY, 1);
        send_item(sstf_pkg::ACT_REQUEST, 4, 'h8000);
        settle();
        write_reg(sstf_pkg::CFG_REQUESTER_COUNT, 2);
        send_item(sstf_pkg::ACT_FINISH, 10, 'h5555);

        while (sent < ITEM_TARGET)
        begin
            settle();
            phase++;
            case ($urandom_range(5, 0))
                0:       cap_pick = 1;
                1:       cap_pick = 16;
                2:       cap_pick = 0;
                3:       cap_pick = $urandom_range(31, 17);
                default: cap_pick = $urandom_range(16, 1);
            endcase
            case ($urandom_range(7, 0))
                0:       live_pick = 0;
                1:       live_pick = 16;
                2:       live_pick = $urandom_range(31, 17);
                default: live_pick = $urandom_range(16, 1);
            endcase
            span = $urandom_range(120, 30);
            if (phase == 4)
            begin
                cap_pick  = 16;
                live_pick = 16;
                span      = 100;
                hold_ask  = 1'b1;
            end
            write_reg(sstf_pkg::CFG_QUEUE_CAPACITY, cap_pick);
            write_reg(sstf_pkg::CFG_REQUESTER_COUNT, live_pick);
            if (sent > ITEM_TARGET - 150)
            begin
                calm = 1'b1;
            end
            repeat (span)
            begin
                act = ($urandom_range(15, 0) == 0) ? sstf_pkg::ACT_FINISH
                                                   : sstf_pkg::ACT_REQUEST;
                rid = $urandom_range(15, 0);
                case ($urandom_range(3, 0))
                    0:       trk = $urandom_range(15, 0);
                    1:       trk = $urandom_range(65535, 65520);
                    default: trk = $urandom_range(65535, 0);
                endcase
                send_item(act, rid, trk);
            end
        end
        settle();

        if (errors == 0 && outstanding == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sstf_disk_request_scheduler.f
rtl/core/sstf_pkg.sv
rtl/core/sstf_cell.sv
rtl/core/sstf_disk_request_scheduler.sv
dv/sstf_service_checker.sv
dv/testbench.sv
